### rtl/adtsdf_pkg.sv
// ADTS deframer package: widths, header constants, result struct and the
// per-frame time step table. No dependencies.

package adtsdf_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int SEC_W    = 32;
    localparam int USEC_W   = 20;
    localparam int STEP_W   = 18;
    localparam int SRI_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // header length counts the 7 header bytes; CRC adds two more
    localparam logic [LEN_W-1:0]  HDR_LEN = 13'd7;
    localparam logic [LEN_W-1:0]  CRC_LEN = 13'd2;
    localparam logic [USEC_W-1:0] US_PER_S = 20'd1000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRATE_IDX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEC  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_USEC = 2'd3;

    typedef struct packed {
        logic                valid;
        logic                has_data;
        logic                last;
        logic [BYTE_W-1:0]   payload;
        logic [LEN_W-1:0]    frame_bytes;
        logic [LEN_W-1:0]    trunc_bytes;
    } adtsdf_res_t;

    // microseconds per 1024-sample frame, by sampling frequency index
    function automatic logic [STEP_W-1:0] frame_step(input logic [SRI_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            4'd0:    s = 18'd10666;
            4'd1:    s = 18'd11609;
            4'd2:    s = 18'd16000;
            4'd3:    s = 18'd21333;
            4'd4:    s = 18'd23219;
            4'd5:    s = 18'd32000;
            4'd6:    s = 18'd42666;
            4'd7:    s = 18'd46439;
            4'd8:    s = 18'd64000;
            4'd9:    s = 18'd85333;
            4'd10:   s = 18'd92879;
            4'd11:   s = 18'd128000;
            4'd12:   s = 18'd139319;
            default: s = 18'd0;
        endcase
        return s;
    endfunction

endpackage

### rtl/adtsdf_parser.sv
// ADTS deframer header/payload sequencer: walks header, CRC and payload
// bytes and forms the per-byte result. Depends on adtsdf_pkg.

module adtsdf_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [adtsdf_pkg::BYTE_W-1:0] data_byte,
    input  logic [adtsdf_pkg::LEN_W-1:0]  max_payload,
    output adtsdf_pkg::adtsdf_res_t       res
);
    import adtsdf_pkg::*;

    localparam logic [3:0] PH_HDR0 = 4'd0;
    localparam logic [3:0] PH_HDR1 = 4'd1;
    localparam logic [3:0] PH_HDR2 = 4'd2;
    localparam logic [3:0] PH_HDR3 = 4'd3;
    localparam logic [3:0] PH_HDR4 = 4'd4;
    localparam logic [3:0] PH_HDR5 = 4'd5;
    localparam logic [3:0] PH_HDR6 = 4'd6;
    localparam logic [3:0] PH_CRC0 = 4'd7;
    localparam logic [3:0] PH_CRC1 = 4'd8;
    localparam logic [3:0] PH_PAY  = 4'd9;

    logic [3:0]        phase_reg, phase_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [LEN_W-1:0]  deliv_reg, deliv_next;
    logic [LEN_W-1:0]  drop_reg, drop_next;
    logic [BYTE_W-1:0] hdr_reg [4];
    logic [LEN_W-1:0]  frame_len, pay_len, remain_dec;
    logic              hdr_we;
    logic [1:0]        hdr_sel;

    assign frame_len  = {hdr_reg[1][1:0], hdr_reg[2], hdr_reg[3][7:5]};
    assign pay_len    = (frame_len > HDR_LEN) ? frame_len - HDR_LEN : '0;
    assign remain_dec = remain_reg - 13'd1;

    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        deliv_next  = deliv_reg;
        drop_next   = drop_reg;
        hdr_we      = 1'b0;
        hdr_sel     = 2'd0;
        res         = '0;
        case (phase_reg)
            PH_HDR0, PH_HDR2: begin
                phase_next = phase_reg + 4'd1;
            end
            PH_HDR1, PH_HDR3, PH_HDR4, PH_HDR5: begin
                hdr_we     = 1'b1;
                hdr_sel    = (phase_reg == PH_HDR1) ? 2'd0 : phase_reg[1:0] - 2'd2;
                phase_next = phase_reg + 4'd1;
            end
            PH_HDR6: begin
                deliv_next = '0;
                drop_next  = '0;
                if (!hdr_reg[0][0]) begin
                    remain_next = (pay_len > CRC_LEN) ? pay_len - CRC_LEN : '0;
                    phase_next  = PH_CRC0;
                end else if (pay_len == '0) begin
                    res.valid   = 1'b1;
                    res.last    = 1'b1;
                    remain_next = '0;
                    phase_next  = PH_HDR0;
                end else begin
                    remain_next = pay_len;
                    phase_next  = PH_PAY;
                end
            end
            PH_CRC0: begin
                phase_next = PH_CRC1;
            end
            PH_CRC1: begin
                if (remain_reg == '0) begin
                    res.valid       = 1'b1;
                    res.last        = 1'b1;
                    res.frame_bytes = deliv_reg;
                    res.trunc_bytes = drop_reg;
                    deliv_next      = '0;
                    drop_next       = '0;
                    phase_next      = PH_HDR0;
                end else begin
                    phase_next = PH_PAY;
                end
            end
            PH_PAY: begin
                remain_next = remain_dec;
                if (deliv_reg < max_payload) begin
                    res.valid    = 1'b1;
                    res.has_data = 1'b1;
                    res.payload  = data_byte;
                    deliv_next   = deliv_reg + 13'd1;
                end else begin
                    drop_next = drop_reg + 13'd1;
                end
                if (remain_dec == '0) begin
                    res.valid       = 1'b1;
                    res.last        = 1'b1;
                    res.frame_bytes = deliv_next;
                    res.trunc_bytes = drop_next;
                    deliv_next      = '0;
                    drop_next       = '0;
                    phase_next      = PH_HDR0;
                end
            end
            default: begin
                phase_next = PH_HDR0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            remain_reg <= '0;
            deliv_reg  <= '0;
            drop_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            deliv_reg  <= deliv_next;
            drop_reg   <= drop_next;
        end
    end

    // header bytes 1, 3, 4, 5; no reset, always written before use
    always_ff @(posedge aclk) begin
        if (step && hdr_we) begin
            hdr_reg[hdr_sel] <= data_byte;
        end
    end

    a_last_returns_to_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.last) |=> (phase_reg == PH_HDR0))
        else $error("frame end did not return to header byte 0");

    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_PAY)
        else $error("sequencer phase out of range");

    a_data_only_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.has_data) |-> (phase_reg == PH_PAY))
        else $error("payload byte forwarded outside payload phase");

endmodule

### rtl/adtsdf_pts.sv
// ADTS deframer presentation time accumulator: start time for the first
// frame, then one frame step per frame with carry. Depends on adtsdf_pkg.

module adtsdf_pts (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [adtsdf_pkg::SRI_W-1:0]  srate_idx,
    input  logic [adtsdf_pkg::SEC_W-1:0]  start_sec,
    input  logic [adtsdf_pkg::USEC_W-1:0] start_usec,
    output logic [adtsdf_pkg::SEC_W-1:0]  sec_next,
    output logic [adtsdf_pkg::USEC_W-1:0] usec_next
);
    import adtsdf_pkg::*;

    logic              first_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic [USEC_W-1:0] usec_reg;
    logic [USEC_W:0]   usec_sum;
    logic              carry;

    // usec_reg can exceed 999999 only from the start value, so one
    // subtract is enough to normalise
    assign usec_sum = {1'b0, usec_reg} + {{(USEC_W+1-STEP_W){1'b0}}, frame_step(srate_idx)};
    assign carry    = usec_sum >= {1'b0, US_PER_S};

    always_comb begin
        if (first_reg) begin
            sec_next  = start_sec;
            usec_next = start_usec;
        end else if (carry) begin
            sec_next  = sec_reg + 32'd1;
            usec_next = USEC_W'(usec_sum - {1'b0, US_PER_S});
        end else begin
            sec_next  = sec_reg;
            usec_next = usec_sum[USEC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            sec_reg   <= '0;
            usec_reg  <= '0;
        end else if (advance) begin
            first_reg <= 1'b0;
            sec_reg   <= sec_next;
            usec_reg  <= usec_next;
        end
    end

    a_first_falls_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(first_reg) |-> $past(advance))
        else $error("first-frame flag cleared without a frame end");

endmodule

### rtl/adts_frame_deframer.sv
// ADTS deframer top level: configuration registers, sequencer, time
// accumulator and result register. Depends on adtsdf_pkg, adtsdf_parser, adtsdf_pts.
//
//  channel | dir | tdata (low bit up)                                   | tuser    | tlast
//  s_      | in  | data_byte[7:0]                                       | -        | -
//  m_      | out | payload_byte, frame_bytes, truncated_bytes,          | has_data | last
//          |     | pts_seconds, pts_microseconds, 2 pad bits (88 total) |          |
//  cfg_    | in  | cfg_we/cfg_addr/cfg_wdata, no read-back              |          |
//
// One byte per cycle while s_tready is high: each byte is handled by the sequencer and
// lands in the result register; m_tvalid rises in the cycle after the s_ transfer.
// s_tready is high while the result register is empty or being taken.
// Header and CRC bytes that give no result take no output slot.
// aresetn is synchronous, active low; no clearing pass after reset.

module adts_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] payload_byte, [20:8] frame_bytes,
                                   // [33:21] truncated_bytes, [65:34] pts_seconds,
                                   // [85:66] pts_microseconds, [87:86] zero
    output logic        m_tuser,   // [0] has_data
    output logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import adtsdf_pkg::*;

    logic [SRI_W-1:0]  srate_idx_reg;
    logic [LEN_W-1:0]  max_pay_reg;
    logic [SEC_W-1:0]  start_sec_reg;
    logic [USEC_W-1:0] start_usec_reg;

    logic              s_accept;
    adtsdf_res_t       res;
    logic [SEC_W-1:0]  sec_next;
    logic [USEC_W-1:0] usec_next;

    logic              m_valid_reg;
    logic              m_user_reg;
    logic              m_last_reg;
    logic [85:0]       m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srate_idx_reg  <= 4'd4;
            max_pay_reg    <= 13'd8191;
            start_sec_reg  <= '0;
            start_usec_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SRATE_IDX:  srate_idx_reg  <= cfg_wdata[SRI_W-1:0];
                CFG_MAX_PAY:    max_pay_reg    <= cfg_wdata[LEN_W-1:0];
                CFG_START_SEC:  start_sec_reg  <= cfg_wdata[SEC_W-1:0];
                CFG_START_USEC: start_usec_reg <= cfg_wdata[USEC_W-1:0];
                default: ;
            endcase
        end
    end

    adtsdf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_accept),
        .data_byte   (s_tdata),
        .max_payload (max_pay_reg),
        .res         (res)
    );

    adtsdf_pts u_pts (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (s_accept && res.last),
        .srate_idx  (srate_idx_reg),
        .start_sec  (start_sec_reg),
        .start_usec (start_usec_reg),
        .sec_next   (sec_next),
        .usec_next  (usec_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= res.valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_user_reg <= res.has_data;
            m_last_reg <= res.last;
            m_data_reg <= {res.last ? usec_next : '0,
                           res.last ? sec_next : '0,
                           res.trunc_bytes,
                           res.frame_bytes,
                           res.payload};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    a_empty_result_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("result without payload byte is not a frame end");

    a_no_accept_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result register stalled");

endmodule
